// File: src/dwc_pkg.sv
// Shared types, field widths, command and register codes for the depthwise convolution block.
package dwc_pkg;

  localparam int CMD_W      = 2;
  localparam int TAP_IDX_W  = 6;
  localparam int VALUE_W    = 16;
  localparam int BIAS_W     = 32;
  localparam int RESULT_W   = 32;
  localparam int POS_W      = 7;
  localparam int PROD_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_MAX_IMAGE_WIDTH  = 128;
  localparam int DEF_MAX_IMAGE_HEIGHT = 128;
  localparam int DEF_MAX_KERNEL       = 7;

  localparam logic [CMD_W-1:0] CMD_TAP   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BIAS  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH    = 4'd7;

  localparam logic [7:0] RST_IMAGE_HEIGHT  = 8'd32;
  localparam logic [7:0] RST_IMAGE_WIDTH   = 8'd32;
  localparam logic [2:0] RST_KERNEL_HEIGHT = 3'd3;
  localparam logic [2:0] RST_KERNEL_WIDTH  = 3'd3;
  localparam logic [7:0] RST_OUT_HEIGHT    = 8'd30;
  localparam logic [7:0] RST_OUT_WIDTH     = 8'd30;
  localparam logic signed [31:0] RST_CLAMP_LOW  = 32'sh8000_0000;
  localparam logic signed [31:0] RST_CLAMP_HIGH = 32'sh7FFF_FFFF;

  typedef logic signed [VALUE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  // Position and bias that travel with one result through the adder stages
  typedef struct packed {
    logic signed [BIAS_W-1:0] bias;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic                     last;
  } meta_t;

endpackage

// File: src/dwc_in_if.sv
// Input channel: command, tap index, sample value and bias.
interface dwc_in_if import dwc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CMD_W-1:0]            command;
  logic [TAP_IDX_W-1:0]        tap_index;
  logic signed [VALUE_W-1:0]   value;
  logic signed [BIAS_W-1:0]    bias_value;

  modport source (output valid, command, tap_index, value, bias_value, input ready);
  modport sink (input valid, command, tap_index, value, bias_value, output ready);
endinterface

// File: src/dwc_out_if.sv
// Result channel: clamped sum with its output position.
interface dwc_out_if import dwc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [RESULT_W-1:0]  result;
  logic [POS_W-1:0]            out_row;
  logic [POS_W-1:0]            out_col;
  logic                        last;

  modport source (output valid, result, out_row, out_col, last, input ready);
  modport sink (input valid, result, out_row, out_col, last, output ready);
endinterface

// File: src/dwc_cfg_if.sv
// Configuration write channel: register index and write data.
interface dwc_cfg_if import dwc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/dwc_cell.sv
// One window cell: a sample register that shifts left and a product register.
module dwc_cell import dwc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    shift_en,
  input  logic    take_right,
  input  logic    take_new,
  input  sample_t right_val,
  input  sample_t new_val,
  input  logic    load_prod,
  input  logic    in_use,
  input  sample_t tap,
  output sample_t sample_q,
  output prod_t   prod_q
);

  sample_t sample_r;
  sample_t sample_nxt;
  prod_t   prod_r;

  always_comb begin
    sample_nxt = sample_r;
    if (shift_en) begin
      if (take_right) begin
        sample_nxt = right_val;
      end else if (take_new) begin
        sample_nxt = new_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else begin
      sample_r <= sample_nxt;
    end
  end

  // product of the window after this beat's shift
  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod_r <= in_use ? prod_t'(sample_nxt * tap) : '0;
    end
  end

  assign sample_q = sample_r;
  assign prod_q   = prod_r;

endmodule

// File: src/dwc_line_store.sv
// Line store: one RAM per kept row, all read at one column with registered data.
module dwc_line_store import dwc_pkg::*; #(
  parameter int SLOTS = 6,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_slot,
  input  logic [$clog2(DEPTH)-1:0]               wr_col,
  input  sample_t                                wr_data,
  input  logic [$clog2(DEPTH)-1:0]               rd_col,
  output sample_t                                rd_q [SLOTS]
);

  localparam int SLOT_W = SLOTS > 1 ? $clog2(SLOTS) : 1;

  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    sample_t mem [DEPTH];
    sample_t rd_r;
    logic    hit;

    assign hit = wr_en && (wr_slot == SLOT_W'(s));

    always_ff @(posedge clk) begin
      if (hit) begin
        mem[wr_col] <= wr_data;
      end
    end

    // forward a same-cycle write to the same column
    always_ff @(posedge clk) begin
      if (hit && (wr_col == rd_col)) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= mem[rd_col];
      end
    end

    assign rd_q[s] = rd_r;
  end

endmodule

// File: src/dwc_accum.sv
// Adder stages: row sums, total plus bias, then clamp into the output register.
module dwc_accum import dwc_pkg::*; #(
  parameter int MAX_KERNEL = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s1_valid,
  output logic                      s1_ready,
  input  prod_t                     prod [MAX_KERNEL][MAX_KERNEL],
  input  meta_t                     meta1,
  input  logic signed [RESULT_W-1:0] clamp_low,
  input  logic signed [RESULT_W-1:0] clamp_high,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [RESULT_W-1:0] out_result,
  output meta_t                     out_meta
);

  localparam int ROW_W = PROD_W + $clog2(MAX_KERNEL + 1);
  localparam int SUM_W = PROD_W + $clog2(MAX_KERNEL * MAX_KERNEL + 1) + 1;

  typedef logic signed [ROW_W-1:0] row_sum_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  logic     v2_r, v3_r, out_valid_r;
  logic     s2_ready, s3_ready;
  row_sum_t row_sum_r [MAX_KERNEL];
  row_sum_t row_sum_nxt [MAX_KERNEL];
  meta_t    meta2_r, meta3_r, meta4_r;
  sum_t     total_r, total_nxt;
  sum_t     clamped;
  logic signed [RESULT_W-1:0] result_r;

  assign s3_ready = !out_valid_r || out_ready;
  assign s2_ready = !v3_r || s3_ready;
  assign s1_ready = !v2_r || s2_ready;

  always_comb begin
    for (int r = 0; r < MAX_KERNEL; r++) begin
      row_sum_nxt[r] = '0;
      for (int c = 0; c < MAX_KERNEL; c++) begin
        row_sum_nxt[r] = row_sum_nxt[r] + ROW_W'(prod[r][c]);
      end
    end
  end

  always_comb begin
    total_nxt = SUM_W'(meta2_r.bias);
    for (int r = 0; r < MAX_KERNEL; r++) begin
      total_nxt = total_nxt + SUM_W'(row_sum_r[r]);
    end
  end

  // low bound first, high bound wins when the bounds cross
  always_comb begin
    clamped = total_r;
    if (clamped < SUM_W'(clamp_low)) begin
      clamped = SUM_W'(clamp_low);
    end
    if (clamped > SUM_W'(clamp_high)) begin
      clamped = SUM_W'(clamp_high);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        v2_r <= s1_valid;
      end
      if (s2_ready) begin
        v3_r <= v2_r;
      end
      if (s3_ready) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      row_sum_r <= row_sum_nxt;
      meta2_r   <= meta1;
    end
    if (s2_ready && v2_r) begin
      total_r <= total_nxt;
      meta3_r <= meta2_r;
    end
    if (s3_ready && v3_r) begin
      result_r <= clamped[RESULT_W-1:0];
      meta4_r  <= meta3_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;
  assign out_meta   = meta4_r;

endmodule

// File: src/depthwise_conv_valid_stride1_top.sv
// Top level of the stride-1, no-padding depthwise convolution block.
//
// One beat is taken per clock while input ready is high: a filter tap, a bias load that
// starts a new channel plane, or a pixel in raster order. The kernel window is a grid of
// shift cells, MAX_KERNEL by MAX_KERNEL, each with its own multiplier; earlier rows of the
// plane sit in one RAM per kept row (MAX_KERNEL-1 of them), read one column ahead with
// registered data. A pixel that closes a window inside the output area yields one result
// beat, registered in turn: products, row sums, total plus bias, clamp into the output.
// The adder stages and the output register stall independently, so input flows while a
// finished result waits, until all stages are full. Input ready is low in the cycle after
// each configuration write while the line store read moves to the new geometry. The line
// store and the tap registers are not cleared at reset: write the taps before use.
module depthwise_conv_valid_stride1_top import dwc_pkg::*; #(
  parameter int MAX_IMAGE_WIDTH  = DEF_MAX_IMAGE_WIDTH,
  parameter int MAX_IMAGE_HEIGHT = DEF_MAX_IMAGE_HEIGHT,
  parameter int MAX_KERNEL       = DEF_MAX_KERNEL
) (
  input  logic      clk,
  input  logic      rst_n,
  dwc_in_if.sink    in_bus,
  dwc_out_if.source out_bus,
  dwc_cfg_if.sink   cfg_bus
);

  localparam int LINE_SLOTS = MAX_KERNEL > 1 ? MAX_KERNEL - 1 : 1;
  localparam int SLOT_W     = LINE_SLOTS > 1 ? $clog2(LINE_SLOTS) : 1;
  localparam int TAP_DEPTH  = MAX_KERNEL * MAX_KERNEL;
  localparam int TAP_IW     = TAP_DEPTH > 1 ? $clog2(TAP_DEPTH) : 1;
  localparam int COL_CAP    = MAX_IMAGE_WIDTH < 128 ? MAX_IMAGE_WIDTH : 128;
  localparam int COL_W      = $clog2(COL_CAP);
  localparam int ADDR_W     = $clog2(MAX_IMAGE_WIDTH);
  localparam int ROW_W      = $clog2(MAX_IMAGE_HEIGHT + 1);
  localparam int KW         = $clog2(MAX_KERNEL + 1);
  localparam int DIM_W      = (ROW_W > 8 ? ROW_W : 8) + 1;
  localparam int SRC_W      = $clog2(2 * LINE_SLOTS + MAX_KERNEL + 1);

  typedef logic [DIM_W-1:0] dim_t;

  // configuration registers
  logic [7:0] image_height_r, image_width_r, out_height_r, out_width_r;
  logic [2:0] kernel_height_r, kernel_width_r;
  logic signed [31:0] clamp_low_r, clamp_high_r;
  logic cfg_hold_r;

  // channel state
  logic signed [BIAS_W-1:0] bias_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  sample_t tap_r [TAP_DEPTH];

  // effective sizes
  logic [ROW_W-1:0] ih;
  logic [COL_W:0]   iw;
  logic [KW-1:0]    kh, kw;
  dim_t oh, ow;

  // this beat's pixel position
  logic in_acc, is_tap, is_bias, is_pixel;
  logic c_wrap, drop, live, produce;
  logic [ROW_W-1:0]  er;
  logic [COL_W-1:0]  ec;
  logic [SLOT_W-1:0] eslot;
  dim_t orow, ocol;
  logic [ADDR_W-1:0] rd_col;

  // stage one
  logic  v1_r, s1_ready, s1_load;
  meta_t meta1_r, meta1_nxt;
  sample_t line_q [LINE_SLOTS];
  sample_t new_val [MAX_KERNEL];
  sample_t win_q [MAX_KERNEL][MAX_KERNEL];
  prod_t   prod_q [MAX_KERNEL][MAX_KERNEL];
  meta_t   out_meta;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(LINE_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port: always ready; input is held off in the cycle afterwards
  // ---------------------------------------------------------------------------
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_height_r  <= RST_IMAGE_HEIGHT;
      image_width_r   <= RST_IMAGE_WIDTH;
      kernel_height_r <= RST_KERNEL_HEIGHT;
      kernel_width_r  <= RST_KERNEL_WIDTH;
      out_height_r    <= RST_OUT_HEIGHT;
      out_width_r     <= RST_OUT_WIDTH;
      clamp_low_r     <= RST_CLAMP_LOW;
      clamp_high_r    <= RST_CLAMP_HIGH;
      cfg_hold_r      <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_bus.valid;
      if (cfg_bus.valid) begin
        unique case (cfg_bus.index)
          REG_IMAGE_HEIGHT:  image_height_r  <= cfg_bus.data[7:0];
          REG_IMAGE_WIDTH:   image_width_r   <= cfg_bus.data[7:0];
          REG_KERNEL_HEIGHT: kernel_height_r <= cfg_bus.data[2:0];
          REG_KERNEL_WIDTH:  kernel_width_r  <= cfg_bus.data[2:0];
          REG_OUT_HEIGHT:    out_height_r    <= cfg_bus.data[7:0];
          REG_OUT_WIDTH:     out_width_r     <= cfg_bus.data[7:0];
          REG_CLAMP_LOW:     clamp_low_r     <= cfg_bus.data;
          REG_CLAMP_HIGH:    clamp_high_r    <= cfg_bus.data;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Effective sizes: zero counts as one, saturate at the build limits
  // ---------------------------------------------------------------------------
  always_comb begin
    if (image_height_r == '0) begin
      ih = ROW_W'(1);
    end else if (DIM_W'(image_height_r) > DIM_W'(MAX_IMAGE_HEIGHT)) begin
      ih = ROW_W'(MAX_IMAGE_HEIGHT);
    end else begin
      ih = ROW_W'(image_height_r);
    end

    if (image_width_r == '0) begin
      iw = (COL_W + 1)'(1);
    end else if (DIM_W'(image_width_r) > DIM_W'(COL_CAP)) begin
      iw = (COL_W + 1)'(COL_CAP);
    end else begin
      iw = (COL_W + 1)'(image_width_r);
    end

    if (kernel_height_r == '0) begin
      kh = KW'(1);
    end else if (DIM_W'(kernel_height_r) > DIM_W'(MAX_KERNEL)) begin
      kh = KW'(MAX_KERNEL);
    end else begin
      kh = KW'(kernel_height_r);
    end

    if (kernel_width_r == '0) begin
      kw = KW'(1);
    end else if (DIM_W'(kernel_width_r) > DIM_W'(MAX_KERNEL)) begin
      kw = KW'(MAX_KERNEL);
    end else begin
      kw = KW'(kernel_width_r);
    end
  end

  // output area, clipped to the valid part of the plane
  always_comb begin
    dim_t oh_cap, ow_cap;
    oh_cap = DIM_W'(ih) - DIM_W'(kh) + 1'b1;
    ow_cap = DIM_W'(iw) - DIM_W'(kw) + 1'b1;
    oh = (DIM_W'(out_height_r) < oh_cap) ? DIM_W'(out_height_r) : oh_cap;
    ow = (DIM_W'(out_width_r) < ow_cap) ? DIM_W'(out_width_r) : ow_cap;
  end

  // ---------------------------------------------------------------------------
  // Input decode and raster position
  // ---------------------------------------------------------------------------
  assign in_bus.ready = (!v1_r || s1_ready) && !cfg_hold_r;
  assign in_acc   = in_bus.valid && in_bus.ready;
  assign is_tap   = in_acc && (in_bus.command == CMD_TAP);
  assign is_bias  = in_acc && (in_bus.command == CMD_BIAS);
  assign is_pixel = in_acc && (in_bus.command == CMD_PIXEL);

  // a column at or past the width (width shrunk mid-row) moves to the next row first
  assign c_wrap = (DIM_W'(col_r) >= DIM_W'(iw));
  assign er     = c_wrap ? row_r + 1'b1 : row_r;
  assign ec     = c_wrap ? '0 : col_r;
  assign eslot  = c_wrap ? slot_inc(slot_r) : slot_r;
  assign drop   = (row_r >= ih) || (er >= ih);
  assign live   = is_pixel && !drop;

  assign orow = DIM_W'(er) + 1'b1 - DIM_W'(kh);
  assign ocol = DIM_W'(ec) + 1'b1 - DIM_W'(kw);

  always_comb begin
    produce = (DIM_W'(er) + 1'b1 >= DIM_W'(kh)) && (DIM_W'(ec) + 1'b1 >= DIM_W'(kw)) &&
              (DIM_W'(ih) >= DIM_W'(kh)) && (DIM_W'(iw) >= DIM_W'(kw)) &&
              (orow < oh) && (ocol < ow);
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    if (is_bias) begin
      row_nxt  = '0;
      col_nxt  = '0;
      slot_nxt = '0;
    end else if (live) begin
      if (DIM_W'(ec) + 1'b1 >= DIM_W'(iw)) begin
        col_nxt  = '0;
        row_nxt  = er + 1'b1;
        slot_nxt = slot_inc(eslot);
      end else begin
        col_nxt  = ec + 1'b1;
        row_nxt  = er;
        slot_nxt = eslot;
      end
    end else if (is_pixel && c_wrap && (row_r < ih)) begin
      // the row step still lands even when the plane then turns out complete
      col_nxt  = '0;
      row_nxt  = er;
      slot_nxt = eslot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
      bias_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
      if (is_bias) begin
        bias_r <= in_bus.bias_value;
      end
    end
  end

  // taps stay in row-major order; each cell picks its own by the kernel width
  always_ff @(posedge clk) begin
    if (is_tap && (DIM_W'(in_bus.tap_index) < DIM_W'(TAP_DEPTH))) begin
      tap_r[TAP_IW'(in_bus.tap_index)] <= in_bus.value;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: read one column ahead at the next pixel's column
  // ---------------------------------------------------------------------------
  assign rd_col = (DIM_W'(col_nxt) >= DIM_W'(iw)) ? '0 : ADDR_W'(col_nxt);

  dwc_line_store #(
    .SLOTS (LINE_SLOTS),
    .DEPTH (MAX_IMAGE_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (live),
    .wr_slot (eslot),
    .wr_col  (ADDR_W'(ec)),
    .wr_data (in_bus.value),
    .rd_col  (rd_col),
    .rd_q    (line_q)
  );

  // value entering the right edge of each window row
  for (genvar r = 0; r < MAX_KERNEL; r++) begin : g_feed
    logic [SRC_W-1:0]  src_tmp;
    logic [SLOT_W-1:0] src_slot;

    assign src_tmp  = SRC_W'(eslot) + SRC_W'(LINE_SLOTS + r + 1) - SRC_W'(kh);
    assign src_slot = (src_tmp >= SRC_W'(LINE_SLOTS)) ? SLOT_W'(src_tmp - SRC_W'(LINE_SLOTS))
                                                      : SLOT_W'(src_tmp);

    always_comb begin
      if (DIM_W'(r + 1) == DIM_W'(kh)) begin
        new_val[r] = in_bus.value;
      end else if (DIM_W'(er) + DIM_W'(r + 1) >= DIM_W'(kh)) begin
        new_val[r] = line_q[src_slot];
      end else begin
        new_val[r] = '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Window cells: shift left on each live pixel, multiply on a producing pixel in the same beat
  // ---------------------------------------------------------------------------
  assign s1_load = live && produce;

  for (genvar r = 0; r < MAX_KERNEL; r++) begin : g_row
    for (genvar c = 0; c < MAX_KERNEL; c++) begin : g_col
      logic [TAP_IW-1:0] tap_sel;
      sample_t           right_val;

      assign tap_sel = TAP_IW'(DIM_W'(r) * DIM_W'(kw) + DIM_W'(c));

      if (c + 1 < MAX_KERNEL) begin : g_mid
        assign right_val = win_q[r][c + 1];
      end else begin : g_edge
        assign right_val = '0;
      end

      dwc_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (live && (DIM_W'(r) < DIM_W'(kh))),
        .take_right (DIM_W'(c + 1) < DIM_W'(kw)),
        .take_new   (DIM_W'(c + 1) == DIM_W'(kw)),
        .right_val  (right_val),
        .new_val    (new_val[r]),
        .load_prod  (s1_load),
        .in_use     ((DIM_W'(r) < DIM_W'(kh)) && (DIM_W'(c) < DIM_W'(kw))),
        .tap        (tap_r[tap_sel]),
        .sample_q   (win_q[r][c]),
        .prod_q     (prod_q[r][c])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Stage one control: position and bias travel with the products
  // ---------------------------------------------------------------------------
  always_comb begin
    meta1_nxt.bias = bias_r;
    meta1_nxt.row  = orow[POS_W-1:0];
    meta1_nxt.col  = ocol[POS_W-1:0];
    meta1_nxt.last = (orow + 1'b1 == oh) && (ocol + 1'b1 == ow);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_load) begin
      v1_r <= 1'b1;
    end else if (s1_ready) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      meta1_r <= meta1_nxt;
    end
  end

  dwc_accum #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (v1_r),
    .s1_ready   (s1_ready),
    .prod       (prod_q),
    .meta1      (meta1_r),
    .clamp_low  (clamp_low_r),
    .clamp_high (clamp_high_r),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_result (out_bus.result),
    .out_meta   (out_meta)
  );

  assign out_bus.out_row = out_meta.row;
  assign out_bus.out_col = out_meta.col;
  assign out_bus.last    = out_meta.last;

endmodule
